>>> rtl/urm_pkg.sv
// ----------------------------------------------------------------------------
// urm_pkg
// Types and constants shared by the ultrasonic range measurer modules.
// ----------------------------------------------------------------------------
package urm_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TICKS_W    = 16;
    localparam int SCALE_W    = 11;
    localparam int DIST_W     = 17;
    localparam int Q_SHIFT    = 10;

    localparam logic [7:0]         TRIG_LOW_RST  = 8'd2;
    localparam logic [7:0]         TRIG_HIGH_RST = 8'd10;
    localparam logic [15:0]        TIMEOUT_RST   = 16'd50000;
    localparam logic [SCALE_W-1:0] SCALE_RST     = 11'd1757;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIG_LOW  = 2'd0,
        CFG_TRIG_HIGH = 2'd1,
        CFG_TIMEOUT   = 2'd2,
        CFG_SCALE     = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LOW  = 2'd1,
        PH_HIGH = 2'd2,
        PH_WAIT = 2'd3
    } t_phase;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    typedef struct packed {
        logic req_type;
        logic echo_level;
    } t_req;

    typedef struct packed {
        logic               trig_level;
        logic               busy_res;
        logic               done_res;
        logic               timed_out;
        logic [TICKS_W-1:0] echo_ticks;
        logic [DIST_W-1:0]  distance;
    } t_res;

    typedef struct packed {
        logic [7:0]         trig_low;
        logic [7:0]         trig_high;
        logic [15:0]        timeout;
        logic [SCALE_W-1:0] scale;
    } t_cfg;

    // result of the control stage, before scaling
    typedef struct packed {
        logic               trig_level;
        logic               busy_res;
        logic               done_res;
        logic               timed_out;
        logic [TICKS_W-1:0] echo_ticks;
    } t_meas;

endpackage

>>> rtl/urm_ctrl.sv
// ----------------------------------------------------------------------------
// urm_ctrl
// Trigger/echo sequencer: updates the measurement state on each accepted
// request and registers the unscaled result.
// ----------------------------------------------------------------------------
module urm_ctrl #(
    parameter int COUNT_WIDTH = urm_pkg::COUNT_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  urm_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  urm_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_take,
    output urm_pkg::t_meas o_meas
);
    import urm_pkg::*;

    localparam int CMPW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_pcnt, n_pcnt;
    logic                   r_eact, n_eact;
    logic [COUNT_WIDTH-1:0] r_ecnt, n_ecnt;
    logic                   r_v1;
    t_meas                  r_meas, n_meas;

    logic [COUNT_WIDTH-1:0] pcnt_inc, ecnt_inc;
    logic [CMPW-1:0]        pcnt_ext, ecnt_ext;
    logic                   accept;

    assign o_ready = !r_v1 || i_take;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_v1;
    assign o_meas  = r_meas;

    assign pcnt_inc = (r_pcnt == CNT_MAX) ? CNT_MAX : r_pcnt + 1'b1;
    assign ecnt_inc = (r_ecnt == CNT_MAX) ? CNT_MAX : r_ecnt + 1'b1;
    assign pcnt_ext = CMPW'(pcnt_inc);
    assign ecnt_ext = CMPW'(ecnt_inc);

    always_comb begin
        n_phase = r_phase;
        n_pcnt  = r_pcnt;
        n_eact  = r_eact;
        n_ecnt  = r_ecnt;
        n_meas  = '0;
        if (i_req.req_type == REQ_START) begin
            if (r_phase == PH_IDLE) begin
                n_phase = PH_LOW;
                n_pcnt  = '0;
                n_eact  = 1'b0;
                n_ecnt  = '0;
            end
            n_meas.trig_level = (r_phase == PH_HIGH);
        end else begin
            case (r_phase)
                PH_LOW: begin
                    n_pcnt = pcnt_inc;
                    if (pcnt_ext >= CMPW'(i_cfg.trig_low)) begin
                        n_phase = PH_HIGH;
                        n_pcnt  = '0;
                    end
                end
                PH_HIGH: begin
                    n_meas.trig_level = 1'b1;
                    n_pcnt = pcnt_inc;
                    if (pcnt_ext >= CMPW'(i_cfg.trig_high)) begin
                        n_phase = PH_WAIT;
                        n_pcnt  = '0;
                        n_eact  = 1'b0;
                        n_ecnt  = '0;
                    end
                end
                PH_WAIT: begin
                    n_pcnt = pcnt_inc;
                    if (r_eact) begin
                        n_ecnt = ecnt_inc;
                        if (!i_req.echo_level) begin
                            n_meas.done_res   = 1'b1;
                            n_meas.echo_ticks = (ecnt_ext > CMPW'(16'hFFFF)) ? '1
                                                : ecnt_ext[TICKS_W-1:0];
                            n_phase = PH_IDLE;
                            n_pcnt  = '0;
                            n_eact  = 1'b0;
                        end
                    end else if (i_req.echo_level) begin
                        n_eact = 1'b1;
                        n_ecnt = '0;
                    end
                    // completion on the same tick wins over the timeout
                    if (!n_meas.done_res && (pcnt_ext >= CMPW'(i_cfg.timeout) ||
                                             pcnt_inc == CNT_MAX)) begin
                        n_meas.timed_out = 1'b1;
                        n_phase = PH_IDLE;
                        n_pcnt  = '0;
                        n_eact  = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
        n_meas.busy_res = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pcnt  <= '0;
            r_eact  <= 1'b0;
            r_ecnt  <= '0;
            r_v1    <= 1'b0;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_pcnt  <= n_pcnt;
                r_eact  <= n_eact;
                r_ecnt  <= n_ecnt;
            end
            if (o_ready) begin
                r_v1 <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_meas <= n_meas;
        end
    end

endmodule

>>> rtl/urm_scale.sv
// ----------------------------------------------------------------------------
// urm_scale
// Output stage: converts echo ticks to distance with the Q10 scale factor
// and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module urm_scale (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [urm_pkg::SCALE_W-1:0]    i_scale,
    input  logic                           i_valid,
    output logic                           o_take,
    input  urm_pkg::t_meas                 i_meas,
    output logic                           o_valid,
    input  logic                           i_ready,
    output urm_pkg::t_res                  o_res
);
    import urm_pkg::*;

    localparam int PROD_W = TICKS_W + SCALE_W;

    logic                r_v2;
    t_res                r_res, n_res;
    logic [PROD_W-1:0]   prod;

    assign o_take  = !r_v2 || i_ready;
    assign o_valid = r_v2;
    assign o_res   = r_res;

    assign prod = PROD_W'(i_meas.echo_ticks) * PROD_W'(i_scale);

    always_comb begin
        n_res            = '0;
        n_res.trig_level = i_meas.trig_level;
        n_res.busy_res   = i_meas.busy_res;
        n_res.done_res   = i_meas.done_res;
        n_res.timed_out  = i_meas.timed_out;
        n_res.echo_ticks = i_meas.echo_ticks;
        n_res.distance   = prod[Q_SHIFT +: DIST_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (o_take) begin
            r_v2 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_res <= n_res;
        end
    end

endmodule

>>> rtl/ultrasonic_range_measurer_core.sv
// ----------------------------------------------------------------------------
// ultrasonic_range_measurer_core
// Ultrasonic echo-ranging controller: trigger sequencing, echo timing and
// distance scaling.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready, i_req) carries one request per item: a
//   one-microsecond tick with the sampled echo level, or a start request.
//   Each request yields exactly one result on the output channel
//   (o_valid/i_ready, o_res) with the trigger level, busy, done and timeout
//   flags, echo duration and distance in hundredths of a centimetre.
//   The result is registered twice after the request is accepted: once
//   together with the sequencer state update, and once after the 16x11
//   scale multiplier. Throughput is one request per cycle while the
//   output does not stall; the sequencer state advances at accept, so
//   back-to-back requests see each other's effects.
//   When the receiver stalls, results are held in the two stage registers
//   and o_ready drops once both are full; nothing is lost or repeated.
//   Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data while
//   no measurement is running. Reset (synchronous, active low) returns the
//   sequencer to idle, empties both stages and loads the register defaults
//   (low 2, high 10, timeout 50000, scale 1757).
// ----------------------------------------------------------------------------
module ultrasonic_range_measurer_core #(
    parameter int COUNT_WIDTH = urm_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [urm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [urm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  urm_pkg::t_req                    i_req,
    output logic                             o_valid,
    input  logic                             i_ready,
    output urm_pkg::t_res                    o_res
);
    import urm_pkg::*;

    t_cfg  r_cfg;
    t_meas meas;
    logic  s1_valid;
    logic  s2_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trig_low  <= TRIG_LOW_RST;
            r_cfg.trig_high <= TRIG_HIGH_RST;
            r_cfg.timeout   <= TIMEOUT_RST;
            r_cfg.scale     <= SCALE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TRIG_LOW:  r_cfg.trig_low  <= i_cfg_data[7:0];
                CFG_TRIG_HIGH: r_cfg.trig_high <= i_cfg_data[7:0];
                CFG_TIMEOUT:   r_cfg.timeout   <= i_cfg_data[15:0];
                CFG_SCALE:     r_cfg.scale     <= i_cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    urm_ctrl #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (s1_valid),
        .i_take  (s2_take),
        .o_meas  (meas)
    );

    urm_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scale (r_cfg.scale),
        .i_valid (s1_valid),
        .o_take  (s2_take),
        .i_meas  (meas),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res)
    );

endmodule

>>> rtl/urm_checker.sv
// ----------------------------------------------------------------------------
// urm_checker
// Port-level checks for the ultrasonic range measurer, bound to the core.
// ----------------------------------------------------------------------------
module urm_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [urm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [urm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    input  logic                             o_ready,
    input  urm_pkg::t_req                    i_req,
    input  logic                             o_valid,
    input  logic                             i_ready,
    input  urm_pkg::t_res                    o_res
);
    import urm_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res))
        else $error("stalled result changed");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.done_res |-> o_res.echo_ticks == '0 && o_res.distance == '0)
        else $error("duration or distance without completion");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_res.done_res && o_res.timed_out))
        else $error("done and timeout together");

    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_res.done_res || o_res.timed_out) |-> !o_res.busy_res)
        else $error("busy after measurement end");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result after reset");

endmodule

bind ultrasonic_range_measurer_core urm_checker u_urm_checker (.*);
